[hdl/whgm_pkg.sv]
// Shared types and constants of the worker heartbeat grace monitor.
package whgm_pkg;

  // Request operation codes.
  typedef enum logic [2:0] {
    OP_BEACON    = 3'd0,
    OP_CHECK     = 3'd1,
    OP_REGISTER  = 3'd2,
    OP_UNREG     = 3'd3,
    OP_ALLOW_ADD = 3'd4,
    OP_ALLOW_REM = 3'd5,
    OP_CLEAR     = 3'd6,
    OP_QUERY     = 3'd7
  } req_op_t;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_NO_CHANGE    = 3'd0,
    EV_CONNECTED    = 3'd1,
    EV_DISCONNECTED = 3'd2,
    EV_REJECTED     = 3'd3,
    EV_TABLE_FULL   = 3'd4,
    EV_DONE_FOUND   = 3'd5,
    EV_NOT_FOUND    = 3'd6,
    EV_CHECK_DONE   = 3'd7
  } event_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ACT,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_FIN
  } seq_state_t;

  // Configuration register map.
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_GRACE_MS      = 2'd0;
  localparam logic [1:0] REG_USE_ALLOW     = 2'd1;
  localparam logic [1:0] REG_CHECK_ENABLED = 2'd2;

  localparam logic [31:0] GRACE_MS_RESET = 32'd10000;
  localparam logic [63:0] ONE_DAY_MS     = 64'd86400000;

  typedef struct packed {
    logic [31:0] grace_ms;
    logic        permit_check_en;
    logic        check_enabled;
  } cfg_t;

endpackage

[hdl/whgm_if.sv]
// Request and result channel interfaces of the heartbeat monitor.
interface whgm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] node_ip;
  logic [15:0] node_port;
  logic [63:0] now_time;
  logic [63:0] beacon_time;
  logic        start_connected;

  modport source (output valid, req_type, node_ip, node_port, now_time, beacon_time,
                  start_connected, input ready);
  modport sink (input valid, req_type, node_ip, node_port, now_time, beacon_time,
                start_connected, output ready);
endinterface

interface whgm_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] out_ip;
  logic [15:0] out_port;
  logic        ack_allowed;
  logic [63:0] ack_time;
  logic        node_alive;
  logic        last_result;

  modport source (output valid, event_res, out_ip, out_port, ack_allowed, ack_time,
                  node_alive, last_result, input ready);
  modport sink (input valid, event_res, out_ip, out_port, ack_allowed, ack_time,
                node_alive, last_result, output ready);
endinterface

[hdl/whgm_mem.sv]
// Single-port-write, single-port-read synchronous memory with registered read data.
module whgm_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/whgm_regs.sv]
// APB configuration registers of the heartbeat monitor.
module whgm_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [whgm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output whgm_pkg::cfg_t            cfg
);
  import whgm_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grace_ms        <= GRACE_MS_RESET;
      cfg.permit_check_en <= 1'b0;
      cfg.check_enabled   <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_GRACE_MS:      cfg.grace_ms        <= pwdata;
        REG_USE_ALLOW:     cfg.permit_check_en <= pwdata[0];
        REG_CHECK_ENABLED: cfg.check_enabled   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_GRACE_MS:      prdata = cfg.grace_ms;
      REG_USE_ALLOW:     prdata = {31'd0, cfg.permit_check_en};
      REG_CHECK_ENABLED: prdata = {31'd0, cfg.check_enabled};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

[hdl/worker_heartbeat_grace_monitor.sv]
// Top level of the worker heartbeat grace monitor: sequencer over node and allow-list memories.
// One request is handled at a time. Every request except a check scans the node table and the
// allow list together, one entry per cycle through the read port of each memory, before the
// next request is taken. A check reads each node entry in turn, and the result channel can stall
// an expiry report; a check while checking is disabled reports completion without reading the
// node table. Results wait in an output register, so the next request is taken while the last
// result is still pending.
module worker_heartbeat_grace_monitor #(
  parameter int unsigned NODE_ENTRIES   = 16,
  parameter int unsigned PERMIT_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [whgm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  whgm_req_if.sink                    req,
  whgm_res_if.source                  res
);
  import whgm_pkg::*;

  localparam int unsigned NW       = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
  localparam int unsigned PW       = (PERMIT_ENTRIES > 1) ? $clog2(PERMIT_ENTRIES) : 1;
  localparam int unsigned SCAN_MAX = (NODE_ENTRIES > PERMIT_ENTRIES) ? NODE_ENTRIES
                                                                     : PERMIT_ENTRIES;
  localparam int unsigned CW       = $clog2(SCAN_MAX + 1);
  localparam int unsigned NDW      = 112;
  localparam int unsigned PDW      = 48;

  cfg_t cfg;

  whgm_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // Latched request.
  logic [2:0]  q_type;
  logic [31:0] q_ip;
  logic [15:0] q_port;
  logic [63:0] q_now;
  logic [63:0] q_btime;
  logic        q_start;

  seq_state_t state, state_next;
  logic [CW-1:0] cnt;

  // Valid and alive marks live in flops so reset and clear take effect at once.
  logic [NODE_ENTRIES-1:0]   entry_valid, entry_valid_next;
  logic [NODE_ENTRIES-1:0]   entry_alive, entry_alive_next;
  logic [PERMIT_ENTRIES-1:0] permit_valid, permit_valid_next;

  // Memory ports.
  logic           n_we, n_re, p_we, p_re;
  logic [NW-1:0]  n_waddr, n_raddr;
  logic [PW-1:0]  p_waddr, p_raddr;
  logic [NDW-1:0] n_wdata, n_rdata;
  logic [PDW-1:0] p_wdata, p_rdata;

  whgm_mem #(.DEPTH(NODE_ENTRIES), .WIDTH(NDW)) u_node_mem (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .re(n_re), .raddr(n_raddr), .rdata(n_rdata)
  );

  whgm_mem #(.DEPTH(PERMIT_ENTRIES), .WIDTH(PDW)) u_permit_mem (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  logic [31:0] rd_ip, rp_ip;
  logic [15:0] rd_port, rp_port;
  logic [63:0] rd_last;
  assign {rd_ip, rd_port, rd_last} = n_rdata;
  assign {rp_ip, rp_port}          = p_rdata;

  // Lookup pipeline and its findings.
  logic          ev_vld, ev_node, ev_perm;
  logic [CW-1:0] ev_idx;
  logic [NW-1:0] ev_nidx;
  logic [PW-1:0] ev_pidx;
  logic          hit, nfree, phit, pfree;
  logic [NW-1:0] hit_idx, nfree_idx;
  logic [PW-1:0] phit_idx, pfree_idx;
  logic [63:0]   hit_last;
  logic          issue;

  assign ev_nidx = ev_idx[NW-1:0];
  assign ev_pidx = ev_idx[PW-1:0];

  // Output register.
  logic        out_valid;
  logic [2:0]  out_ev;
  logic [31:0] out_ip_q;
  logic [15:0] out_port_q;
  logic        out_allowed;
  logic [63:0] out_time;
  logic        out_alive;
  logic        out_last;
  logic        out_free;

  logic        emit;
  event_t      e_ev;
  logic [31:0] e_ip;
  logic [15:0] e_port;
  logic        e_allowed;
  logic [63:0] e_time;
  logic        e_alive;
  logic        e_last;
  logic        expire;
  logic        in_day;

  assign out_free  = !out_valid || res.ready;
  assign req.ready = (state == ST_IDLE);
  assign in_day    = (q_now - hit_last) <= ONE_DAY_MS;
  assign expire    = entry_valid[cnt[NW-1:0]] && entry_alive[cnt[NW-1:0]]
                     && ((q_now - rd_last) > {32'd0, cfg.grace_ms});

  // Next state, memory control and result selection.
  always_comb begin
    state_next        = state;
    entry_valid_next  = entry_valid;
    entry_alive_next  = entry_alive;
    permit_valid_next = permit_valid;
    n_we    = 1'b0;
    n_waddr = hit ? hit_idx : nfree_idx;
    n_wdata = {q_ip, q_port, q_now};
    n_re    = 1'b0;
    n_raddr = cnt[NW-1:0];
    p_we    = 1'b0;
    p_waddr = pfree_idx;
    p_wdata = {q_ip, q_port};
    p_re    = 1'b0;
    p_raddr = cnt[PW-1:0];
    issue   = 1'b0;
    emit      = 1'b0;
    e_ev      = EV_NO_CHANGE;
    e_ip      = q_ip;
    e_port    = q_port;
    e_allowed = 1'b0;
    e_time    = 64'd0;
    e_alive   = 1'b0;
    e_last    = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req_op_t'(req.req_type) == OP_CHECK) begin
            state_next = cfg.check_enabled ? ST_CHK_RD : ST_FIN;
          end else begin
            state_next = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (cnt != CW'(SCAN_MAX)) begin
          issue = 1'b1;
          n_re  = cnt < CW'(NODE_ENTRIES);
          p_re  = cnt < CW'(PERMIT_ENTRIES);
        end else if (!ev_vld) begin
          state_next = ST_ACT;
        end
      end
      ST_ACT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          unique case (req_op_t'(q_type))
            OP_BEACON: begin
              e_allowed = 1'b1;
              e_time    = q_btime;
              if (hit) begin
                e_alive = entry_alive[hit_idx];
                if (in_day) begin
                  n_we = 1'b1;
                  entry_alive_next[hit_idx] = 1'b1;
                  e_alive = 1'b1;
                  if (!entry_alive[hit_idx]) begin
                    e_ev = EV_CONNECTED;
                  end
                end
              end else if (cfg.permit_check_en && !phit) begin
                e_ev      = EV_REJECTED;
                e_allowed = 1'b0;
              end else if (!nfree) begin
                e_ev = EV_TABLE_FULL;
              end else begin
                n_we = 1'b1;
                entry_valid_next[nfree_idx] = 1'b1;
                entry_alive_next[nfree_idx] = 1'b1;
                e_ev    = EV_CONNECTED;
                e_alive = 1'b1;
              end
            end
            OP_REGISTER: begin
              if (hit) begin
                e_alive = entry_alive[hit_idx];
              end else if (!nfree) begin
                e_ev = EV_TABLE_FULL;
              end else begin
                n_we = 1'b1;
                entry_valid_next[nfree_idx] = 1'b1;
                entry_alive_next[nfree_idx] = q_start;
                e_ev    = EV_DONE_FOUND;
                e_alive = q_start;
              end
            end
            OP_UNREG: begin
              if (hit) begin
                entry_valid_next[hit_idx] = 1'b0;
                entry_alive_next[hit_idx] = 1'b0;
                e_ev = EV_DONE_FOUND;
              end else begin
                e_ev = EV_NOT_FOUND;
              end
            end
            OP_ALLOW_ADD: begin
              if (phit) begin
                e_ev = EV_NO_CHANGE;
              end else if (!pfree) begin
                e_ev = EV_TABLE_FULL;
              end else begin
                p_we = 1'b1;
                permit_valid_next[pfree_idx] = 1'b1;
                e_ev = EV_DONE_FOUND;
              end
            end
            OP_ALLOW_REM: begin
              if (phit) begin
                permit_valid_next[phit_idx] = 1'b0;
                e_ev = EV_DONE_FOUND;
              end else begin
                e_ev = EV_NOT_FOUND;
              end
            end
            OP_CLEAR: begin
              entry_valid_next = '0;
              entry_alive_next = '0;
              e_ev = EV_DONE_FOUND;
            end
            OP_QUERY: begin
              if (hit) begin
                e_ev    = EV_DONE_FOUND;
                e_alive = entry_alive[hit_idx];
              end else begin
                e_ev = EV_NOT_FOUND;
              end
            end
            OP_CHECK: begin
              e_ev = EV_CHECK_DONE;
            end
          endcase
        end
      end
      ST_CHK_RD: begin
        n_re       = 1'b1;
        state_next = ST_CHK_EV;
      end
      ST_CHK_EV: begin
        e_ip   = rd_ip;
        e_port = rd_port;
        e_ev   = EV_DISCONNECTED;
        e_last = 1'b0;
        if (!expire || out_free) begin
          if (expire) begin
            emit = 1'b1;
            entry_alive_next[cnt[NW-1:0]] = 1'b0;
          end
          state_next = (cnt == CW'(NODE_ENTRIES - 1)) ? ST_FIN : ST_CHK_RD;
        end
      end
      ST_FIN: begin
        e_ev   = EV_CHECK_DONE;
        e_ip   = 32'd0;
        e_port = 16'd0;
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_valid  <= '0;
      entry_alive  <= '0;
      permit_valid <= '0;
      out_valid    <= 1'b0;
      ev_vld       <= 1'b0;
      cnt          <= '0;
    end else begin
      state        <= state_next;
      entry_valid  <= entry_valid_next;
      entry_alive  <= entry_alive_next;
      permit_valid <= permit_valid_next;
      ev_vld       <= issue;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (issue || (state == ST_CHK_EV && state_next == ST_CHK_RD)) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  // Request capture and lookup findings.
  always_ff @(posedge clk) begin
    ev_idx  <= cnt;
    ev_node <= cnt < CW'(NODE_ENTRIES);
    ev_perm <= cnt < CW'(PERMIT_ENTRIES);
    if (req.valid && req.ready) begin
      q_type  <= req.req_type;
      q_ip    <= req.node_ip;
      q_port  <= req.node_port;
      q_now   <= req.now_time;
      q_btime <= req.beacon_time;
      q_start <= req.start_connected;
      hit     <= 1'b0;
      nfree   <= 1'b0;
      phit    <= 1'b0;
      pfree   <= 1'b0;
    end else if (ev_vld) begin
      if (ev_node && entry_valid[ev_nidx] && rd_ip == q_ip && rd_port == q_port && !hit) begin
        hit      <= 1'b1;
        hit_idx  <= ev_nidx;
        hit_last <= rd_last;
      end
      if (ev_node && !entry_valid[ev_nidx] && !nfree) begin
        nfree     <= 1'b1;
        nfree_idx <= ev_nidx;
      end
      if (ev_perm && permit_valid[ev_pidx] && rp_ip == q_ip && rp_port == q_port && !phit) begin
        phit     <= 1'b1;
        phit_idx <= ev_pidx;
      end
      if (ev_perm && !permit_valid[ev_pidx] && !pfree) begin
        pfree     <= 1'b1;
        pfree_idx <= ev_pidx;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_ev      <= e_ev;
      out_ip_q    <= e_ip;
      out_port_q  <= e_port;
      out_allowed <= e_allowed;
      out_time    <= e_time;
      out_alive   <= e_alive;
      out_last    <= e_last;
    end
  end

  assign res.valid       = out_valid;
  assign res.event_res   = out_ev;
  assign res.out_ip      = out_ip_q;
  assign res.out_port    = out_port_q;
  assign res.ack_allowed = out_allowed;
  assign res.ack_time    = out_time;
  assign res.node_alive  = out_alive;
  assign res.last_result = out_last;

  // An alive mark never outlives its entry.
  assert property (@(posedge clk) disable iff (rst) (entry_alive & ~entry_valid) == '0)
    else $error("alive mark set on an invalid node entry");

  // A check never evaluates beyond the node table.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK_EV) |-> (cnt < CW'(NODE_ENTRIES)))
    else $error("check scan index out of range");

  // Finishing a request always leaves a result in the output register.
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_ACT || state == ST_FIN) && out_free) |=> res.valid)
    else $error("final result not presented");

  // The lookup pipeline is empty whenever the block waits for a request.
  assert property (@(posedge clk) disable iff (rst) (state == ST_IDLE) |-> !ev_vld)
    else $error("lookup still in flight while idle");

endmodule
